[sv/escf_pkg.sv]
// Shared types and constants for the escaped frame receiver.
// Item structs, result kind codes, register map and reset values.
// No dependencies.
package escf_pkg;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_START   = 3'd0;
  localparam logic [2:0] REG_END     = 3'd1;
  localparam logic [2:0] REG_ESCAPE  = 3'd2;
  localparam logic [2:0] REG_MAX_PAY = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  localparam logic [7:0]  RST_START   = 8'd2;
  localparam logic [7:0]  RST_END     = 8'd3;
  localparam logic [7:0]  RST_ESCAPE  = 8'd16;
  localparam logic [7:0]  RST_MAX_PAY = 8'd64;
  localparam logic [15:0] RST_TIMEOUT = 16'd100;

  localparam logic [2:0] KIND_BYTE     = 3'd0;
  localparam logic [2:0] KIND_END      = 3'd1;
  localparam logic [2:0] KIND_OVERFLOW = 3'd2;
  localparam logic [2:0] KIND_BADESC   = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [8:0] CHECK_BYTES = 9'd2;

  typedef struct packed {
    logic       mode;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] body_byte;
    logic [8:0] position;
    logic [7:0] response_code;
    logic [7:0] status_code;
    logic [8:0] body_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
    logic [7:0]  escape_byte;
    logic [7:0]  max_payload;
    logic [15:0] frame_timeout;
  } cfg_t;

endpackage

[sv/escf_cfg.sv]
// APB register block for the escaped frame receiver.
// Holds framing bytes, payload limit and timeout; depends on escf_pkg.
module escf_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [escf_pkg::ADDR_W-1:0]   paddr,
  input  logic [escf_pkg::DATA_W-1:0]   pwdata,
  output logic [escf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output escf_pkg::cfg_t                cfg
);
  import escf_pkg::*;

  logic [2:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte    <= RST_START;
      cfg.end_byte      <= RST_END;
      cfg.escape_byte   <= RST_ESCAPE;
      cfg.max_payload   <= RST_MAX_PAY;
      cfg.frame_timeout <= RST_TIMEOUT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START:   cfg.start_byte    <= pwdata[7:0];
        REG_END:     cfg.end_byte      <= pwdata[7:0];
        REG_ESCAPE:  cfg.escape_byte   <= pwdata[7:0];
        REG_MAX_PAY: cfg.max_payload   <= pwdata[7:0];
        REG_TIMEOUT: cfg.frame_timeout <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_START:   prdata = {24'd0, cfg.start_byte};
      REG_END:     prdata = {24'd0, cfg.end_byte};
      REG_ESCAPE:  prdata = {24'd0, cfg.escape_byte};
      REG_MAX_PAY: prdata = {24'd0, cfg.max_payload};
      REG_TIMEOUT: prdata = {16'd0, cfg.frame_timeout};
      default:     prdata = '0;
    endcase
  end

endmodule

[sv/escf_fsm.sv]
// Deframing state machine: one byte or tick per accepted item.
// Produces at most one result per item; depends on escf_pkg.
module escf_fsm #(
  parameter int TIMER_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  escf_pkg::in_item_t  item,
  input  escf_pkg::cfg_t      cfg,
  output logic                res_valid,
  output escf_pkg::out_item_t res
);
  import escf_pkg::*;

  localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_RESPONSE = 3'd1,
    PH_STATUS   = 3'd2,
    PH_BODY     = 3'd3,
    PH_ESCAPE   = 3'd4
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            response_reg, response_reg_next;
  logic [7:0]            status_reg, status_reg_next;
  logic [8:0]            body_index, body_index_next;
  logic [TIMER_BITS-1:0] elapsed_ticks, elapsed_ticks_next;

  logic [TIMER_BITS-1:0] ticks_inc;
  logic                  timed_out;
  logic [8:0]            body_limit;
  logic                  full;
  logic                  esc_ok;
  logic                  do_store;
  logic [7:0]            store_val;
  logic [7:0]            b;

  assign b          = item.rx_byte;
  assign ticks_inc  = (elapsed_ticks == {TIMER_BITS{1'b1}}) ? elapsed_ticks
                                                            : elapsed_ticks + 1'b1;
  assign timed_out  = CMP_W'(ticks_inc) > CMP_W'(cfg.frame_timeout);
  assign body_limit = {1'b0, cfg.max_payload} + CHECK_BYTES;
  assign full       = body_index >= body_limit;
  assign esc_ok     = (b == (cfg.escape_byte ^ ESC_XOR)) ||
                      (b == (cfg.start_byte ^ ESC_XOR)) ||
                      (b == (cfg.end_byte ^ ESC_XOR));

  always_comb begin
    phase_next         = phase;
    response_reg_next  = response_reg;
    status_reg_next    = status_reg;
    body_index_next    = body_index;
    elapsed_ticks_next = elapsed_ticks;
    do_store           = 1'b0;
    store_val          = b;
    res_valid          = 1'b0;
    res                = '0;
    res.response_code  = response_reg;
    res.status_code    = status_reg;

    if (accept) begin
      if (item.mode) begin
        if (phase != PH_IDLE) begin
          elapsed_ticks_next = ticks_inc;
          if (timed_out) begin
            phase_next      = PH_IDLE;
            body_index_next = '0;
            res_valid       = 1'b1;
            res.kind        = KIND_TIMEOUT;
          end
        end
      end else begin
        unique case (phase)
          PH_RESPONSE: begin
            response_reg_next = b;
            phase_next        = PH_STATUS;
          end
          PH_STATUS: begin
            status_reg_next = b;
            body_index_next = '0;
            phase_next      = PH_BODY;
          end
          PH_BODY: begin
            if (b == cfg.escape_byte) begin
              phase_next = PH_ESCAPE;
            end else if (b == cfg.end_byte) begin
              phase_next     = PH_IDLE;
              res_valid      = 1'b1;
              res.kind       = KIND_END;
              res.body_count = body_index;
            end else begin
              do_store = 1'b1;
            end
          end
          PH_ESCAPE: begin
            if (esc_ok) begin
              phase_next = PH_BODY;
              do_store   = 1'b1;
              store_val  = b ^ ESC_XOR;
            end else begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = KIND_BADESC;
            end
          end
          default: begin
            // idle: hunt for the start byte
            phase_next = PH_IDLE;
            if (b == cfg.start_byte) begin
              phase_next         = PH_RESPONSE;
              elapsed_ticks_next = '0;
            end
          end
        endcase

        if (do_store) begin
          res_valid = 1'b1;
          if (full) begin
            phase_next = PH_IDLE;
            res.kind   = KIND_OVERFLOW;
          end else begin
            body_index_next = body_index + 1'b1;
            res.kind        = KIND_BYTE;
            res.body_byte   = store_val;
            res.position    = body_index;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      response_reg  <= '0;
      status_reg    <= '0;
      body_index    <= '0;
      elapsed_ticks <= '0;
    end else begin
      phase         <= phase_next;
      response_reg  <= response_reg_next;
      status_reg    <= status_reg_next;
      body_index    <= body_index_next;
      elapsed_ticks <= elapsed_ticks_next;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    body_index <= 9'd257)
    else $error("body index beyond limit");

  a_abandon_idle: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind != KIND_BYTE) |=> phase == PH_IDLE)
    else $error("frame not closed after end or error");

  a_idle_tick_quiet: assert property (@(posedge clk) disable iff (rst)
    (accept && item.mode && phase == PH_IDLE) |-> !res_valid)
    else $error("result from tick while idle");

  a_timeout_clears: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_TIMEOUT) |=> body_index == '0)
    else $error("timeout left body index set");

endmodule

[sv/escf_skid.sv]
// Two-entry output stage: result register plus skid register.
// Lets the input side keep going while a result waits; depends on escf_pkg.
module escf_skid (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  escf_pkg::out_item_t push_item,
  output logic                space,
  output logic                result_valid,
  input  logic                result_ready,
  output escf_pkg::out_item_t result
);
  import escf_pkg::*;

  logic      main_valid;
  logic      skid_valid;
  out_item_t main_item;
  out_item_t skid_item;
  logic      pop;

  assign pop          = main_valid && result_ready;
  assign space        = !skid_valid;
  assign result_valid = main_valid;
  assign result       = main_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_item <= skid_item;
      end
    end else if (push) begin
      if (main_valid && !pop) begin
        skid_item <= push_item;
      end else begin
        main_item <= push_item;
      end
    end
  end

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry without result entry");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("item pushed into full output stage");

endmodule

[sv/escaped_frame_receiver_core.sv]
// Top level of the escaped frame receiver: register block, deframer, output stage.
// Depends on escf_pkg, escf_cfg, escf_fsm and escf_skid.
//
//  channel   direction  handshake                      payload
//  item      in         item_valid / item_ready        in_item_t (mode, rx_byte)
//  result    out        result_valid / result_ready    out_item_t
//  apb       in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One item per cycle while item_ready holds; results are registered before the port.
// The deframer state updates at the accepting edge; results pass through a
// two-entry output stage, so item_ready drops only when both entries are full.
// Reset is synchronous: idle phase, cleared counters, registers at defaults.
module escaped_frame_receiver_core #(
  parameter int TIMER_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  escf_pkg::in_item_t           item,
  output logic                         result_valid,
  input  logic                         result_ready,
  output escf_pkg::out_item_t          result,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [escf_pkg::ADDR_W-1:0]  paddr,
  input  logic [escf_pkg::DATA_W-1:0]  pwdata,
  output logic [escf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import escf_pkg::*;

  cfg_t      cfg;
  logic      accept;
  logic      res_valid;
  out_item_t res;
  logic      space;

  assign item_ready = space;
  assign accept     = item_valid && space;

  escf_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  escf_fsm #(
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  escf_skid u_skid (
    .clk          (clk),
    .rst          (rst),
    .push         (res_valid),
    .push_item    (res),
    .space        (space),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[dv/escf_tb_pkg.sv]
// Checking side of the escaped frame receiver testbench: a cycle-free model of the
// deframer that turns accepted items into the frame reports it should emit.
// Depends on escf_pkg for item structs, kind codes and register map.
package escf_tb_pkg;
  import escf_pkg::*;

  typedef enum logic [2:0] {HUNT, GET_RESP, GET_STATUS, IN_BODY, AFTER_ESC} rx_phase_t;

  class escf_frame_shadow;
    cfg_t        cfg;
    rx_phase_t   phase;
    logic [7:0]  resp;
    logic [7:0]  stat;
    logic [8:0]  body_idx;
    logic [15:0] ticks;
    out_item_t   queued[$];
    int unsigned errors;

    function new();
      cfg = '{RST_START, RST_END, RST_ESCAPE, RST_MAX_PAY, RST_TIMEOUT};
      phase = HUNT;
      resp = '0;
      stat = '0;
      body_idx = '0;
      ticks = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] v);
      case (idx)
        REG_START:   cfg.start_byte = v[7:0];
        REG_END:     cfg.end_byte = v[7:0];
        REG_ESCAPE:  cfg.escape_byte = v[7:0];
        REG_MAX_PAY: cfg.max_payload = v[7:0];
        REG_TIMEOUT: cfg.frame_timeout = v[15:0];
        default: ;
      endcase
    endfunction

    function out_item_t store_byte(logic [7:0] b);
      out_item_t r;
      r = '0;
      if (body_idx >= 9'(cfg.max_payload) + CHECK_BYTES) begin
        phase = HUNT;
        r.kind = KIND_OVERFLOW;
      end else begin
        r.kind = KIND_BYTE;
        r.body_byte = b;
        r.position = body_idx;
        body_idx++;
      end
      return r;
    endfunction

    function void take_item(in_item_t it);
      out_item_t  r;
      bit         hit;
      logic [7:0] b;
      r = '0;
      hit = 1'b0;
      b = it.rx_byte;
      if (it.mode) begin
        if (phase != HUNT) begin
          if (ticks != '1) ticks++;
          if (ticks > cfg.frame_timeout) begin
            phase = HUNT;
            body_idx = '0;
            hit = 1'b1;
            r.kind = KIND_TIMEOUT;
          end
        end
      end else begin
        case (phase)
          HUNT: begin
            if (b == cfg.start_byte) begin
              phase = GET_RESP;
              ticks = '0;
            end
          end
          GET_RESP: begin
            resp = b;
            phase = GET_STATUS;
          end
          GET_STATUS: begin
            stat = b;
            body_idx = '0;
            phase = IN_BODY;
          end
          IN_BODY: begin
            // escape wins over end when both registers hold the same value
            if (b == cfg.escape_byte) begin
              phase = AFTER_ESC;
            end else if (b == cfg.end_byte) begin
              phase = HUNT;
              hit = 1'b1;
              r.kind = KIND_END;
              r.body_count = body_idx;
            end else begin
              hit = 1'b1;
              r = store_byte(b);
            end
          end
          default: begin
            hit = 1'b1;
            if (b == (cfg.escape_byte ^ ESC_XOR) || b == (cfg.start_byte ^ ESC_XOR) ||
                b == (cfg.end_byte ^ ESC_XOR)) begin
              phase = IN_BODY;
              r = store_byte(b ^ ESC_XOR);
            end else begin
              phase = HUNT;
              r.kind = KIND_BADESC;
            end
          end
        endcase
      end
      if (hit) begin
        r.response_code = resp;
        r.status_code = stat;
        queued.push_back(r);
      end
    endfunction

    task flag_mismatch(string what);
      $display("[%0t] MISMATCH %s", $time, what);
      errors++;
    endtask

    task cmp(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    endtask

    task match_report(out_item_t got);
      out_item_t want;
      if (queued.size() == 0) begin
        flag_mismatch($sformatf("result with nothing pending, kind %0h", got.kind));
        return;
      end
      want = queued.pop_front();
      cmp("kind", 32'(got.kind), 32'(want.kind));
      cmp("body_byte", 32'(got.body_byte), 32'(want.body_byte));
      cmp("position", 32'(got.position), 32'(want.position));
      cmp("response_code", 32'(got.response_code), 32'(want.response_code));
      cmp("status_code", 32'(got.status_code), 32'(want.status_code));
      cmp("body_count", 32'(got.body_count), 32'(want.body_count));
    endtask

    task check_empty();
      if (queued.size() != 0) flag_mismatch($sformatf("%0d results never came", queued.size()));
    endtask
  endclass

endpackage

[dv/tb_top.sv]
// Top of the escaped frame receiver testbench: clock, reset, item and APB drivers,
// result sink with stalls, and the run sequence over several register settings.
// Depends on escf_pkg, escf_tb_pkg and escaped_frame_receiver_core.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import escf_pkg::*;
  import escf_tb_pkg::*;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                item_valid = 1'b0;
  logic                item_ready;
  in_item_t            item = '0;
  logic                result_valid;
  logic                result_ready = 1'b0;
  out_item_t           result;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  escf_frame_shadow tracker = new();

  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned holdoff_requests = 0;
  bit          gapless = 1'b0;
  bit          offering = 1'b0;

  escaped_frame_receiver_core dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) tracker.match_report(result);
  end

  initial begin : result_sink
    int unsigned served, hold_left, seg_left, style;
    served = 0;
    hold_left = 0;
    seg_left = 0;
    style = 0;
    forever begin
      @(posedge clk);
      if (served != holdoff_requests) begin
        served++;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          style = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 60);
        end
        seg_left--;
        case (style)
          0: result_ready <= 1'b1;
          1: result_ready <= 1'($urandom_range(0, 1));
          2: result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  task automatic send_item(input logic m, input logic [7:0] b);
    in_item_t it;
    it.mode = m;
    it.rx_byte = b;
    item_valid <= 1'b1;
    item <= it;
    offering = 1'b1;
    do @(posedge clk); while (!item_ready);
    tracker.take_item(it);
    items_sent++;
    if (!gapless) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        item_valid <= 1'b0;
        offering = 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 30);
      end
    end
  endtask

  task automatic send_tick();
    send_item(1'b1, 8'($urandom));
  endtask

  task automatic send_body_byte();
    logic [7:0]  v;
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) v = tracker.cfg.start_byte;
    else if (pick == 1) v = tracker.cfg.end_byte;
    else if (pick == 2) v = tracker.cfg.escape_byte;
    else v = 8'($urandom);
    if (v == tracker.cfg.escape_byte || v == tracker.cfg.end_byte ||
        (v == tracker.cfg.start_byte && $urandom_range(0, 1) == 1)) begin
      send_item(1'b0, tracker.cfg.escape_byte);
      send_item(1'b0, v ^ ESC_XOR);
    end else begin
      send_item(1'b0, v);
    end
  endtask

  task automatic send_frame();
    int unsigned limit, len, roll;
    logic [7:0]  bad;
    limit = int'(tracker.cfg.max_payload) + 2;
    repeat ($urandom_range(0, 2)) send_item(1'b0, 8'($urandom));
    if ($urandom_range(0, 5) == 0) send_tick();
    send_item(1'b0, tracker.cfg.start_byte);
    send_item(1'b0, 8'($urandom));
    send_item(1'b0, 8'($urandom));
    roll = $urandom_range(0, 19);
    if (roll == 0) len = limit + $urandom_range(1, 3);
    else if (roll == 1) len = limit;
    else len = $urandom_range(0, (limit < 10) ? limit : 10);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_tick();
      if ($urandom_range(0, 39) == 0) begin
        do bad = 8'($urandom);
        while (bad == (tracker.cfg.escape_byte ^ ESC_XOR) ||
               bad == (tracker.cfg.start_byte ^ ESC_XOR) ||
               bad == (tracker.cfg.end_byte ^ ESC_XOR));
        send_item(1'b0, tracker.cfg.escape_byte);
        send_item(1'b0, bad);
        return;
      end
      send_body_byte();
    end
    if ($urandom_range(0, 24) == 0 && tracker.cfg.frame_timeout <= 120)
      repeat (int'(tracker.cfg.frame_timeout) + 1) send_tick();
    if ($urandom_range(0, 9) != 0) send_item(1'b0, tracker.cfg.end_byte);
  endtask

  task automatic drain();
    if (offering) begin
      item_valid <= 1'b0;
      offering = 1'b0;
    end
    while (tracker.queued.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // back-to-back transfers: the next setup follows the access directly
  task automatic apb_write(input logic [2:0] idx, input logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_reg(idx, v);
  endtask

  task automatic write_cfg(input cfg_t c);
    apb_write(REG_START, {24'd0, c.start_byte});
    apb_write(REG_END, {24'd0, c.end_byte});
    apb_write(REG_ESCAPE, {24'd0, c.escape_byte});
    apb_write(REG_MAX_PAY, {24'd0, c.max_payload});
    apb_write(REG_TIMEOUT, {16'd0, c.frame_timeout});
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    cfg_t        plan[6];
    int unsigned base;
    logic [8:0]  opening[$];
    logic [8:0]  tight[$];
    // bit 8 set marks a timer tick
    opening = '{9'h100, 9'h0FF, 9'h000, 9'h002, 9'h0FF, 9'h000, 9'h000, 9'h0FF, 9'h002,
                9'h010, 9'h030, 9'h010, 9'h022, 9'h010, 9'h023, 9'h1FF, 9'h003,
                9'h002, 9'h05A, 9'h0A5, 9'h010, 9'h041, 9'h002, 9'h001, 9'h080, 9'h003};
    tight = '{9'h000, 9'h012, 9'h034, 9'h011, 9'h022, 9'h033, 9'h000, 9'h001, 9'h002,
              9'h100, 9'h155, 9'h000, 9'h0AB, 9'h0CD, 9'h07D, 9'h05D, 9'h0FF};
    plan[0] = '{RST_START, RST_END, RST_ESCAPE, RST_MAX_PAY, RST_TIMEOUT};
    plan[1] = '{8'h00, 8'hFF, 8'h7D, 8'd0, 16'd0};
    plan[2] = '{8'hFF, 8'h00, 8'hFF, 8'd255, 16'hFFFF};
    plan[3] = '{8'h7E, 8'h55, 8'h55, 8'd1, 16'd12};
    plan[4] = '{8'hAA, 8'hAA, 8'h33, 8'd3, 16'd40};
    plan[5] = '{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(1, 16)),
                16'($urandom_range(1, 80))};

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[i]) send_item(opening[i][8], opening[i][7:0]);

    for (int p = 0; p < 6; p++) begin
      drain();
      write_cfg(plan[p]);
      base = items_sent;
      case (p)
        0: begin
          // stall the result side while a long frame streams in
          holdoff_requests <= holdoff_requests + 1;
          gapless = 1'b1;
          send_item(1'b0, tracker.cfg.start_byte);
          send_item(1'b0, 8'h5C);
          send_item(1'b0, 8'hC5);
          repeat (60) send_item(1'b0, 8'($urandom_range(8'h40, 8'hFF)));
          send_item(1'b0, tracker.cfg.end_byte);
          gapless = 1'b0;
        end
        1: foreach (tight[i]) send_item(tight[i][8], tight[i][7:0]);
        2: begin
          // a long tick run stays under the largest limit
          gapless = 1'b1;
          send_item(1'b0, tracker.cfg.start_byte);
          send_item(1'b0, 8'($urandom));
          send_item(1'b0, 8'($urandom));
          repeat (200) send_tick();
          send_item(1'b0, 8'h41);
          send_item(1'b0, tracker.cfg.end_byte);
          gapless = 1'b0;
        end
        default: ;
      endcase
      while (items_sent - base < 325) send_frame();
    end

    drain();
    repeat (20) @(posedge clk);
    tracker.check_empty();
    if (tracker.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #15_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
